/* rtl/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg: shared types, constants and helpers
// Fixed-point formats, CORDIC arctangent table and small helper functions
// used by the great-circle distance and course pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // datapath width of CORDIC x, y and z (Q30, signed)
    localparam int DW               = 36;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CORDIC_STEPS_MAX = 32;

    localparam logic signed [DW-1:0] GAIN_INV_Q30 = 36'sd652032874;
    localparam logic signed [DW-1:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [DW-1:0] HALF_PI_Q30  = 36'sd1686629713;
    localparam logic signed [DW-1:0] TWO_PI_Q30   = 36'sd6746518853;

    // angle reduction in 1e-7 degree units
    localparam logic signed [33:0] FULL_TURN_U    = 34'sd3600000000;
    localparam logic signed [33:0] HALF_TURN_U    = 34'sd1800000000;
    localparam logic signed [33:0] QUARTER_TURN_U = 34'sd900000000;
    localparam logic signed [58:0] DEG7_TO_RAD_Q24 = 59'sd31441057;
    localparam logic signed [58:0] DEG_ROUND       = 59'sd8388608;

    localparam logic signed [59:0] SPHERE_RADIUS_M = 60'sd6372795;
    localparam logic [24:0]        DIST_MAX_M      = 25'd20021069;

    // course scaling: centidegrees = round(crs * 18000 / PI)
    localparam longint            CDEG_SCALE_L = 18000;
    localparam int                RECIP_SHIFT  = 40;
    localparam longint            RECIP_L      =
        (CDEG_SCALE_L * (64'sd1 <<< RECIP_SHIFT) + 64'sd1686629713) / 64'sd3373259426;
    localparam logic signed [63:0] RECIP_Q40   = 64'(RECIP_L);
    localparam logic signed [63:0] RECIP_HALF  = 64'sd1 <<< (RECIP_SHIFT - 1);
    localparam logic signed [51:0] CDEG_SCALE  = 52'sd18000;
    localparam logic signed [17:0] CDEG_TURN   = 18'sd36000;

    // reduced angle with cosine sign flag
    typedef struct packed {
        logic signed [31:0] r;
        logic               neg_cos;
    } red_t;

    // vectoring start point after quarter-turn pre-rotation
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } vec_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [DW-1:0] atan_q30(input logic [4:0] i);
        logic signed [DW-1:0] v;
        case (i)
            5'd0:    v = 36'sh0_3243_F6A8;
            5'd1:    v = 36'sh0_1DAC_6705;
            5'd2:    v = 36'sh0_0FAD_BAFC;
            5'd3:    v = 36'sh0_07F5_6EA6;
            5'd4:    v = 36'sh0_03FE_AB76;
            5'd5:    v = 36'sh0_01FF_D55B;
            5'd6:    v = 36'sh0_00FF_FAAA;
            5'd7:    v = 36'sh0_007F_FF55;
            5'd8:    v = 36'sh0_003F_FFEA;
            5'd9:    v = 36'sh0_001F_FFFD;
            5'd10:   v = 36'sh0_000F_FFFF;
            5'd11:   v = 36'sh0_0007_FFFF;
            5'd12:   v = 36'sh0_0003_FFFF;
            5'd13:   v = 36'sh0_0001_FFFF;
            5'd14:   v = 36'sh0_0000_FFFF;
            5'd15:   v = 36'sh0_0000_7FFF;
            5'd16:   v = 36'sh0_0000_3FFF;
            5'd17:   v = 36'sh0_0000_1FFF;
            5'd18:   v = 36'sh0_0000_0FFF;
            5'd19:   v = 36'sh0_0000_07FF;
            5'd20:   v = 36'sh0_0000_03FF;
            5'd21:   v = 36'sh0_0000_01FF;
            5'd22:   v = 36'sh0_0000_00FF;
            5'd23:   v = 36'sh0_0000_007F;
            5'd24:   v = 36'sh0_0000_003F;
            5'd25:   v = 36'sh0_0000_001F;
            5'd26:   v = 36'sh0_0000_000F;
            5'd27:   v = 36'sh0_0000_0008;
            5'd28:   v = 36'sh0_0000_0004;
            5'd29:   v = 36'sh0_0000_0002;
            5'd30:   v = 36'sh0_0000_0001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // reduce to [-180, 180) deg, then fold to [-90, 90] deg
    function automatic red_t reduce_angle(input logic signed [33:0] u);
        logic signed [33:0] t;
        red_t               res;
        t = u;
        if (t >= FULL_TURN_U) begin
            t = t - FULL_TURN_U;
        end else if (t <= -FULL_TURN_U) begin
            t = t + FULL_TURN_U;
        end
        if (t >= HALF_TURN_U) begin
            t = t - FULL_TURN_U;
        end else if (t < -HALF_TURN_U) begin
            t = t + FULL_TURN_U;
        end
        res.neg_cos = 1'b0;
        if (t > QUARTER_TURN_U) begin
            t = HALF_TURN_U - t;
            res.neg_cos = 1'b1;
        end else if (t < -QUARTER_TURN_U) begin
            t = -HALF_TURN_U - t;
            res.neg_cos = 1'b1;
        end
        res.r = 32'(t);
        return res;
    endfunction

    // quarter-turn pre-rotation into the right half plane
    function automatic vec_t pre_rotate(input logic signed [DW-1:0] x,
                                        input logic signed [DW-1:0] y);
        vec_t v;
        v.x = x;
        v.y = y;
        v.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI_Q30;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI_Q30;
            end
        end
        return v;
    endfunction

endpackage

/* rtl/gcd_cordic_stage.sv */
// ----------------------------------------------------------------------------
// gcd_cordic_stage: one registered CORDIC iteration
// Rotation or vectoring micro-rotation by atan(2^-IDX) with a sideband word
// carried alongside; advances only when the pipeline enable is high.
// ----------------------------------------------------------------------------
module gcd_cordic_stage #(
    parameter int DW        = gcd_pkg::DW,
    parameter int IDX       = 0,
    parameter bit VECTORING = 1'b0,
    parameter int SIDE_W    = 1
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    input  logic signed [DW-1:0] z_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output logic signed [DW-1:0] z_out,
    output logic [SIDE_W-1:0]    side_out
);

    logic signed [DW-1:0] dx, dy, at;
    logic                 cw;
    logic signed [DW-1:0] x_next, y_next, z_next;
    logic signed [DW-1:0] x_reg, y_reg, z_reg;
    logic [SIDE_W-1:0]    side_reg;

    // direction from residual angle (rotation) or y sign (vectoring)
    always_comb begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        at = gcd_pkg::atan_q30(5'(IDX));
        cw = VECTORING ? ~y_in[DW-1] : z_in[DW-1];
        if (cw) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + at;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

/* rtl/great_circle_distance_and_course_unit.sv */
// ----------------------------------------------------------------------------
// great_circle_distance_and_course_unit: distance and initial course
// Great-circle distance in meters and initial course in centidegrees
// between two positions, fully pipelined with unrolled CORDIC chains.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transaction carries a position pair, tdata holds
//   lat_from[30:0], lon_from[62:31], lat_to[93:63], lon_to[125:94]
//   (1e-7 degree units, signed).
//   Output stream m_*: one transaction per input, tdata holds
//   distance_m[24:0] and course_cdeg[40:25].
//   The pipeline holds a sin/cos rotation chain, then two vectoring chains
//   in series (course and magnitude, then central angle), with multiply
//   stages between them.
//   Throughput is one transaction per cycle; the whole pipeline advances on
//   one enable, so an item enters in every cycle while the output is free.
//   When the receiver stalls with a result held in the output register,
//   the pipeline freezes and s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module great_circle_distance_and_course_unit #(
    parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // lat_from, lon_from, lat_to, lon_to
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata    // distance_m, course_cdeg
);

    localparam int DW  = gcd_pkg::DW;
    localparam int NS  = (CORDIC_STEPS > gcd_pkg::CORDIC_STEPS_MAX) ?
                         gcd_pkg::CORDIC_STEPS_MAX : CORDIC_STEPS;
    localparam int LAT = 3 * NS + 10;

    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    // pipeline enable: move unless the output holds an untaken result
    assign en       = ~vld_reg[LAT-1] | m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    // valid bits travel with the data
    always_comb begin
        vld_next = {vld_reg[LAT-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 1: angle reduction ----------------
    logic signed [33:0] u_in [3];
    gcd_pkg::red_t      red_reg [3];

    always_comb begin
        u_in[0] = 34'(signed'(s_tdata[30:0]));
        u_in[1] = 34'(signed'(s_tdata[93:63]));
        u_in[2] = 34'(signed'(s_tdata[125:94])) - 34'(signed'(s_tdata[62:31]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                red_reg[l] <= gcd_pkg::reduce_angle(u_in[l]);
            end
        end
    end

    // ---------------- stage 2: degree to radian ----------------
    logic signed [58:0]   zp [3];
    logic signed [DW-1:0] rot_x [3][NS+1];
    logic signed [DW-1:0] rot_y [3][NS+1];
    logic signed [DW-1:0] rot_z [3][NS+1];
    logic [0:0]           rot_n [3][NS+1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            zp[l] = (59'(red_reg[l].r) * gcd_pkg::DEG7_TO_RAD_Q24 + gcd_pkg::DEG_ROUND)
                    >>> 24;
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_rot_init
        always_ff @(posedge aclk) begin
            if (en) begin
                rot_x[l][0] <= gcd_pkg::GAIN_INV_Q30;
                rot_y[l][0] <= '0;
                rot_z[l][0] <= DW'(zp[l]);
                rot_n[l][0] <= red_reg[l].neg_cos;
            end
        end
    end

    // ---------------- sin/cos rotation chains ----------------
    for (genvar l = 0; l < 3; l++) begin : g_rot_lane
        for (genvar k = 0; k < NS; k++) begin : g_rot_step
            gcd_cordic_stage #(
                .DW(DW), .IDX(k), .VECTORING(1'b0), .SIDE_W(1)
            ) u_rot (
                .aclk    (aclk),
                .en      (en),
                .x_in    (rot_x[l][k]),
                .y_in    (rot_y[l][k]),
                .z_in    (rot_z[l][k]),
                .side_in (rot_n[l][k]),
                .x_out   (rot_x[l][k+1]),
                .y_out   (rot_y[l][k+1]),
                .z_out   (rot_z[l][k+1]),
                .side_out(rot_n[l][k+1])
            );
        end
    end

    // ---------------- product stage 1 ----------------
    logic signed [31:0] sn [3];
    logic signed [31:0] cs [3];
    logic signed [63:0] m_c1s2, m_s1c2, m_c2sd, m_s1s2, m_c1c2;
    logic signed [32:0] p_c1s2_reg, p_s1c2_reg, p_c2sd_reg, p_s1s2_reg, p_c1c2_reg;
    logic signed [31:0] cd_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            sn[l] = 32'(rot_y[l][NS]);
            cs[l] = rot_n[l][NS][0] ? 32'(-rot_x[l][NS]) : 32'(rot_x[l][NS]);
        end
        m_c1s2 = 64'(cs[0]) * 64'(sn[1]);
        m_s1c2 = 64'(sn[0]) * 64'(cs[1]);
        m_c2sd = 64'(cs[1]) * 64'(sn[2]);
        m_s1s2 = 64'(sn[0]) * 64'(sn[1]);
        m_c1c2 = 64'(cs[0]) * 64'(cs[1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_c1s2_reg <= 33'(m_c1s2 >>> 30);
            p_s1c2_reg <= 33'(m_s1c2 >>> 30);
            p_c2sd_reg <= 33'(m_c2sd >>> 30);
            p_s1s2_reg <= 33'(m_s1s2 >>> 30);
            p_c1c2_reg <= 33'(m_c1c2 >>> 30);
            cd_reg     <= cs[2];
        end
    end

    // ---------------- product stage 2 ----------------
    logic signed [65:0] m_q1, m_q2;
    logic signed [33:0] q1_reg, q2_reg, p1_reg, p3_reg, p4_reg;

    always_comb begin
        m_q1 = 66'(p_s1c2_reg) * 66'(cd_reg);
        m_q2 = 66'(p_c1c2_reg) * 66'(cd_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_reg <= 34'(m_q1 >>> 30);
            q2_reg <= 34'(m_q2 >>> 30);
            p1_reg <= 34'(p_c1s2_reg);
            p3_reg <= 34'(p_c2sd_reg);
            p4_reg <= 34'(p_s1s2_reg);
        end
    end

    // ---------------- sum stage, course pre-rotation ----------------
    logic signed [DW-1:0] a_val, b_val, d_val;
    gcd_pkg::vec_t        v1_start;
    logic signed [DW-1:0] v1_x [NS+1];
    logic signed [DW-1:0] v1_y [NS+1];
    logic signed [DW-1:0] v1_z [NS+1];
    logic [DW:0]          v1_s [NS+1];

    always_comb begin
        a_val    = DW'(p1_reg) - DW'(q1_reg);
        b_val    = DW'(p3_reg);
        d_val    = DW'(p4_reg) + DW'(q2_reg);
        v1_start = gcd_pkg::pre_rotate(a_val, b_val);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_x[0] <= v1_start.x;
            v1_y[0] <= v1_start.y;
            v1_z[0] <= v1_start.z;
            v1_s[0] <= {(a_val == '0) && (b_val == '0), d_val};
        end
    end

    // ---------------- course / magnitude vectoring chain ----------------
    for (genvar k = 0; k < NS; k++) begin : g_vec1
        gcd_cordic_stage #(
            .DW(DW), .IDX(k), .VECTORING(1'b1), .SIDE_W(DW+1)
        ) u_vec1 (
            .aclk    (aclk),
            .en      (en),
            .x_in    (v1_x[k]),
            .y_in    (v1_y[k]),
            .z_in    (v1_z[k]),
            .side_in (v1_s[k]),
            .x_out   (v1_x[k+1]),
            .y_out   (v1_y[k+1]),
            .z_out   (v1_z[k+1]),
            .side_out(v1_s[k+1])
        );
    end

    // ---------------- magnitude gain correction ----------------
    logic signed [71:0]   m_mag;
    logic signed [DW-1:0] mag_reg, crs_reg, d_reg;
    logic                 zero1;

    always_comb begin
        zero1 = v1_s[NS][DW];
        m_mag = 72'(v1_x[NS]) * 72'(gcd_pkg::GAIN_INV_Q30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= zero1 ? '0 : DW'(m_mag >>> 30);
            crs_reg <= zero1 ? '0 : v1_z[NS];
            d_reg   <= v1_s[NS][DW-1:0];
        end
    end

    // ---------------- central angle pre-rotation ----------------
    gcd_pkg::vec_t        v2_start;
    logic signed [DW-1:0] v2_x [NS+1];
    logic signed [DW-1:0] v2_y [NS+1];
    logic signed [DW-1:0] v2_z [NS+1];
    logic [DW:0]          v2_s [NS+1];

    always_comb begin
        v2_start = gcd_pkg::pre_rotate(d_reg, mag_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v2_x[0] <= v2_start.x;
            v2_y[0] <= v2_start.y;
            v2_z[0] <= v2_start.z;
            v2_s[0] <= {(d_reg == '0) && (mag_reg == '0), crs_reg};
        end
    end

    // ---------------- central angle vectoring chain ----------------
    for (genvar k = 0; k < NS; k++) begin : g_vec2
        gcd_cordic_stage #(
            .DW(DW), .IDX(k), .VECTORING(1'b1), .SIDE_W(DW+1)
        ) u_vec2 (
            .aclk    (aclk),
            .en      (en),
            .x_in    (v2_x[k]),
            .y_in    (v2_y[k]),
            .z_in    (v2_z[k]),
            .side_in (v2_s[k]),
            .x_out   (v2_x[k+1]),
            .y_out   (v2_y[k+1]),
            .z_out   (v2_z[k+1]),
            .side_out(v2_s[k+1])
        );
    end

    // ---------------- final stage 1: scale distance and course ----------------
    logic signed [DW-1:0] ang, crs_w;
    logic signed [59:0]   m_dist;
    logic signed [63:0]   m_est;
    logic signed [51:0]   nume;
    logic signed [DW-1:0] dist_raw_reg;
    logic signed [17:0]   est_reg;
    logic signed [51:0]   nume_reg;

    always_comb begin
        ang = v2_s[NS][DW] ? '0 : v2_z[NS];
        if (ang < 0) begin
            ang = '0;
        end
        crs_w = v2_s[NS][DW-1:0];
        if (crs_w < 0) begin
            crs_w = crs_w + gcd_pkg::TWO_PI_Q30;
        end
        if (crs_w < 0) begin
            crs_w = '0;
        end
        m_dist = 60'(ang) * gcd_pkg::SPHERE_RADIUS_M;
        m_est  = 64'(crs_w) * gcd_pkg::RECIP_Q40 + gcd_pkg::RECIP_HALF;
        nume   = 52'(crs_w) * gcd_pkg::CDEG_SCALE + 52'(gcd_pkg::HALF_PI_Q30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_raw_reg <= DW'(m_dist >>> 30);
            est_reg      <= 18'(m_est >>> gcd_pkg::RECIP_SHIFT);
            nume_reg     <= nume;
        end
    end

    // ---------------- final stage 2: remainder and saturation ----------------
    logic signed [51:0] rem;
    logic signed [51:0] rem_reg;
    logic signed [17:0] est2_reg;
    logic [24:0]        dist_reg;

    always_comb begin
        rem = nume_reg - 52'(est_reg) * 52'(gcd_pkg::PI_Q30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem;
            est2_reg <= est_reg;
            dist_reg <= (dist_raw_reg > DW'(gcd_pkg::DIST_MAX_M)) ?
                        gcd_pkg::DIST_MAX_M : 25'(dist_raw_reg);
        end
    end

    // ---------------- output register: quotient correction, wrap ----------------
    logic signed [17:0] cdeg;
    logic [15:0]        course_reg;
    logic [24:0]        dist_out_reg;

    always_comb begin
        cdeg = est2_reg;
        if (rem_reg < 0) begin
            cdeg = cdeg - 18'sd1;
        end else if (rem_reg >= 52'(gcd_pkg::PI_Q30)) begin
            cdeg = cdeg + 18'sd1;
        end
        if (cdeg >= gcd_pkg::CDEG_TURN) begin
            cdeg = cdeg - gcd_pkg::CDEG_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            course_reg   <= 16'(cdeg);
            dist_out_reg <= dist_reg;
        end
    end

    assign m_tdata = {7'b0, course_reg, dist_out_reg};

endmodule

/* rtl/gcd_checker.sv */
// ----------------------------------------------------------------------------
// gcd_checker: port-level checks for the distance and course unit
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module gcd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [127:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input is taken exactly when the output register can move
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // distance saturates at DIST_MAX_M, 20021069 m
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[24:0] <= 25'd20021069)
        else $error("distance out of range");

    // course is wrapped into one turn
    a_course_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[40:25] < 16'd36000)
        else $error("course out of range");

endmodule

bind great_circle_distance_and_course_unit gcd_checker u_gcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
